// File: src/cba_pkg.sv
// Shared types, sizes and codes of the contiguous block allocator.
package cba_pkg;

    localparam int BLOCKS  = 1024;
    localparam int FILES   = 64;
    localparam int BLK_AW  = $clog2(BLOCKS);
    localparam int BLK_CW  = $clog2(BLOCKS + 1);
    localparam int BLK_XW  = $clog2(2 * BLOCKS + 1);
    localparam int FILE_AW = $clog2(FILES);
    localparam int FILE_CW = $clog2(FILES + 1);
    localparam int SIZE_W  = 23;
    localparam int BB_W    = 13;
    localparam int BIU_W   = 11;
    localparam int QW      = SIZE_W + 1;
    localparam int DCW     = $clog2(QW);
    localparam int KIND_W  = 2;
    localparam int STAT_W  = 2;
    localparam int START_W = 10;
    localparam int FREE_W  = 11;
    localparam int FID_W   = 6;
    localparam int CIDX_W  = 1;
    localparam int CDAT_W  = 13;

    typedef logic [BLK_AW-1:0]  t_blk;
    typedef logic [BLK_CW-1:0]  t_cnt;
    typedef logic [BLK_XW-1:0]  t_wide;
    typedef logic [QW-1:0]      t_quo;
    typedef logic [DCW-1:0]     t_dcnt;
    typedef logic [FILE_AW-1:0] t_fidx;
    typedef logic [FILE_CW-1:0] t_fcnt;
    typedef logic [BB_W-1:0]    t_rem;
    typedef logic [SIZE_W-1:0]  t_size;

    typedef logic [KIND_W-1:0] t_kind;
    localparam t_kind KIND_CREATE = 2'd0;
    localparam t_kind KIND_DELETE = 2'd1;
    localparam t_kind KIND_RESIZE = 2'd2;
    localparam t_kind KIND_UNUSED = 2'd3;

    typedef logic [STAT_W-1:0] t_status;
    localparam t_status ST_OK         = 2'd0;
    localparam t_status ST_OK_COMPACT = 2'd1;
    localparam t_status ST_NO_SPACE   = 2'd2;
    localparam t_status ST_NO_FILE    = 2'd3;

    typedef logic [CIDX_W-1:0] t_cidx;
    localparam t_cidx REG_BLOCK_BYTES   = 1'd0;
    localparam t_cidx REG_BLOCKS_IN_USE = 1'd1;

    typedef struct packed {
        t_blk  start;
        logic  placed;
        t_size bytes;
        t_cnt  held;
    } t_ent;

endpackage

// File: src/cba_if.sv
// Request, response and configuration channel interfaces of the allocator.
interface cba_req_if;
    logic                                valid;
    logic                                ready;
    logic [cba_pkg::KIND_W-1:0]          kind;
    logic [cba_pkg::FID_W-1:0]           file_id;
    logic [cba_pkg::SIZE_W-1:0]          new_size;
    modport source (output valid, kind, file_id, new_size, input ready);
    modport sink   (input valid, kind, file_id, new_size, output ready);
endinterface

interface cba_rsp_if;
    logic                                valid;
    logic                                ready;
    logic [cba_pkg::STAT_W-1:0]          status;
    logic [cba_pkg::START_W-1:0]         start_block;
    logic                                placed;
    logic [cba_pkg::FREE_W-1:0]          free_count;
    modport source (output valid, status, start_block, placed, free_count, input ready);
    modport sink   (input valid, status, start_block, placed, free_count, output ready);
endinterface

interface cba_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [cba_pkg::CIDX_W-1:0]          index;
    logic [cba_pkg::CDAT_W-1:0]          data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: src/contiguous_block_allocator_unit.sv
// Contiguous block allocator: used-block bitmap and file table in RAM, with compaction.
// One transaction at a time. After reset the bitmap is cleared in a pass over all BLOCKS (1024)
// blocks during which no transaction is accepted. Every operation ends with a count of free
// blocks over the effective block count E. Create adds a first-free scan, resize adds the
// block rounding divider and a bitmap run check, and shrink or delete clear each freed block
// in the bitmap. When growth needs compaction, the bitmap is cleared and then each placed
// file gets a file table scan and a placement that marks its held blocks. The bitmap RAM
// has a single port pair (one read, one write per cycle).
module contiguous_block_allocator_unit (
    input  logic           i_clk,
    input  logic           i_rst_n,
    cba_req_if.sink        i_req,
    cba_rsp_if.source      o_rsp,
    cba_cfg_if.sink        i_cfg
);

    typedef enum logic [4:0] {
        S_CLR, S_IDLE, S_LOAD, S_MARK, S_DIV, S_RSZ, S_TX, S_FF, S_RUN, S_TXOK,
        S_TXFAIL, S_CHK, S_CSTART, S_CFI, S_CFIND, S_CPLACE, S_CGROW, S_WENT,
        S_CNT0, S_CNT, S_OUT
    } t_state;

    // storage
    logic                  map_mem [cba_pkg::BLOCKS];
    cba_pkg::t_ent         ent_mem [cba_pkg::FILES];
    logic                  r_map_q;
    cba_pkg::t_ent         r_ent_q;

    logic                  map_we;
    cba_pkg::t_blk         map_waddr;
    logic                  map_wdata;
    cba_pkg::t_blk         map_raddr;
    logic                  ent_we;
    cba_pkg::t_fidx        ent_waddr;
    cba_pkg::t_ent         ent_wdata;
    cba_pkg::t_fidx        ent_raddr;

    t_state                r_state, n_state;
    t_state                r_ret, n_ret;
    cba_pkg::t_kind        r_kind, n_kind;
    cba_pkg::t_fidx        r_f, n_f;
    cba_pkg::t_size        r_nsz, n_nsz;
    cba_pkg::t_ent         r_ent, n_ent;
    logic                  r_entv, n_entv;
    cba_pkg::t_status      r_status, n_status;
    cba_pkg::t_wide        r_addr, n_addr;
    cba_pkg::t_wide        r_cnt, n_cnt;
    logic                  r_pend, n_pend;
    cba_pkg::t_wide        r_paddr, n_paddr;
    cba_pkg::t_cnt         r_run, n_run;
    cba_pkg::t_wide        r_pos, n_pos;
    cba_pkg::t_quo         r_need, n_need;
    logic                  r_second, n_second;
    cba_pkg::t_cnt         r_free, n_free;
    cba_pkg::t_rem         r_rem, n_rem;
    cba_pkg::t_quo         r_quo, n_quo;
    cba_pkg::t_dcnt        r_dcnt, n_dcnt;
    logic                  r_mval, n_mval;
    logic                  r_create, n_create;
    cba_pkg::t_fcnt        r_fidx, n_fidx;
    logic                  r_fpend, n_fpend;
    cba_pkg::t_fidx        r_fpaddr, n_fpaddr;
    logic                  r_bfound, n_bfound;
    cba_pkg::t_fidx        r_bidx, n_bidx;
    cba_pkg::t_ent         r_best, n_best;
    cba_pkg::t_wide        r_next, n_next;
    logic [cba_pkg::FILES-1:0] r_valid, n_valid;
    logic [cba_pkg::FILES-1:0] r_done, n_done;
    logic [cba_pkg::BB_W-1:0]  r_bb, n_bb;
    logic [cba_pkg::BIU_W-1:0] r_biu, n_biu;
    logic                  r_ovalid, n_ovalid;
    cba_pkg::t_status      r_ostatus, n_ostatus;
    logic [cba_pkg::START_W-1:0] r_ostart, n_ostart;
    logic                  r_oplaced, n_oplaced;
    logic [cba_pkg::FREE_W-1:0]  r_ofree, n_ofree;

    // helpers
    cba_pkg::t_cnt         eff;
    cba_pkg::t_wide        effx;
    logic [cba_pkg::BB_W-1:0] ubb;
    cba_pkg::t_ent         ent_in;
    logic [cba_pkg::BB_W:0]   rem_sh;
    logic                  ge;
    cba_pkg::t_quo         tgt;
    cba_pkg::t_quo         need;
    cba_pkg::t_cnt         tmin;
    cba_pkg::t_cnt         run1;
    cba_pkg::t_cnt         fin;
    logic                  can;
    logic                  cand;
    logic                  bf;

    always_ff @(posedge i_clk) begin
        if (map_we) begin
            map_mem[map_waddr] <= map_wdata;
        end
        r_map_q <= map_mem[map_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (ent_we) begin
            ent_mem[ent_waddr] <= ent_wdata;
        end
        r_ent_q <= ent_mem[ent_raddr];
    end

    assign i_req.ready       = (r_state == S_IDLE);
    assign i_cfg.ready       = 1'b1;
    assign o_rsp.valid       = r_ovalid;
    assign o_rsp.status      = r_ostatus;
    assign o_rsp.start_block = r_ostart;
    assign o_rsp.placed      = r_oplaced;
    assign o_rsp.free_count  = r_ofree;

    always_comb begin
        if (32'(r_biu) > cba_pkg::BLOCKS) begin
            eff = cba_pkg::t_cnt'(cba_pkg::BLOCKS);
        end else begin
            eff = cba_pkg::t_cnt'(r_biu);
        end
        effx = cba_pkg::t_wide'(eff);
        ubb  = (r_bb == '0) ? cba_pkg::BB_W'(1) : r_bb;
    end

    always_comb begin
        n_state = r_state;   n_ret = r_ret;       n_kind = r_kind;     n_f = r_f;
        n_nsz = r_nsz;       n_ent = r_ent;       n_entv = r_entv;     n_status = r_status;
        n_addr = r_addr;     n_cnt = r_cnt;       n_pend = r_pend;     n_paddr = r_paddr;
        n_run = r_run;       n_pos = r_pos;       n_need = r_need;     n_second = r_second;
        n_free = r_free;     n_rem = r_rem;       n_quo = r_quo;       n_dcnt = r_dcnt;
        n_mval = r_mval;     n_create = r_create; n_fidx = r_fidx;     n_fpend = r_fpend;
        n_fpaddr = r_fpaddr; n_bfound = r_bfound; n_bidx = r_bidx;     n_best = r_best;
        n_next = r_next;     n_valid = r_valid;   n_done = r_done;     n_bb = r_bb;
        n_biu = r_biu;       n_ostatus = r_ostatus; n_ostart = r_ostart;
        n_oplaced = r_oplaced; n_ofree = r_ofree;
        n_ovalid = r_ovalid && !o_rsp.ready;

        map_we    = 1'b0;
        map_waddr = r_addr[cba_pkg::BLK_AW-1:0];
        map_wdata = 1'b0;
        map_raddr = r_addr[cba_pkg::BLK_AW-1:0];
        ent_we    = 1'b0;
        ent_waddr = r_f;
        ent_wdata = r_ent;
        ent_raddr = r_fidx[cba_pkg::FILE_AW-1:0];

        ent_in = r_valid[r_f] ? r_ent_q : '0;
        rem_sh = {r_rem, r_quo[cba_pkg::QW-1]};
        ge     = (rem_sh >= {1'b0, ubb});
        tgt    = r_quo;
        need   = (tgt > cba_pkg::t_quo'(r_ent.held)) ?
                 tgt - cba_pkg::t_quo'(r_ent.held) : '0;
        tmin   = (tgt > cba_pkg::t_quo'(r_ent.held)) ? r_ent.held : tgt[cba_pkg::BLK_CW-1:0];
        run1   = r_run + cba_pkg::t_cnt'(r_pend);
        can    = (cba_pkg::t_quo'(r_cnt) < r_need) && (r_addr < effx);
        fin    = (r_pend && r_map_q) ? r_run : run1;
        cand   = r_fpend && r_valid[r_fpaddr] && !r_done[r_fpaddr] && (r_fpaddr != r_f) &&
                 r_ent_q.placed && (!r_bfound || (r_ent_q.start < r_best.start));
        bf     = r_bfound || cand;

        if (i_cfg.valid) begin
            case (i_cfg.index)
                cba_pkg::REG_BLOCK_BYTES:   n_bb  = i_cfg.data;
                cba_pkg::REG_BLOCKS_IN_USE: n_biu = i_cfg.data[cba_pkg::BIU_W-1:0];
                default: ;
            endcase
        end

        case (r_state)
            S_CLR: begin
                map_we = 1'b1;
                if (r_addr == cba_pkg::t_wide'(cba_pkg::BLOCKS - 1)) begin
                    n_state = r_ret;
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end
            S_IDLE: begin
                ent_raddr = i_req.file_id;
                if (i_req.valid) begin
                    n_kind  = i_req.kind;
                    n_f     = i_req.file_id;
                    n_nsz   = i_req.new_size;
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                n_ent    = ent_in;
                n_entv   = r_valid[r_f];
                n_status = cba_pkg::ST_OK;
                n_ret    = S_OUT;
                n_addr   = '0;
                n_pend   = 1'b0;
                n_state  = S_CNT0;
                case (r_kind)
                    cba_pkg::KIND_CREATE: begin
                        if (!r_valid[r_f]) begin
                            n_create = 1'b1;
                            n_state  = S_FF;
                        end
                    end
                    cba_pkg::KIND_DELETE: begin
                        if (!r_valid[r_f]) begin
                            n_status = cba_pkg::ST_NO_FILE;
                        end else begin
                            n_ent  = '0;
                            n_entv = 1'b0;
                            if (ent_in.placed) begin
                                n_addr  = cba_pkg::t_wide'(ent_in.start);
                                n_cnt   = cba_pkg::t_wide'(ent_in.held);
                                n_mval  = 1'b0;
                                n_ret   = S_WENT;
                                n_state = S_MARK;
                            end else begin
                                n_state = S_WENT;
                            end
                        end
                    end
                    cba_pkg::KIND_RESIZE: begin
                        if (!r_valid[r_f]) begin
                            n_status = cba_pkg::ST_NO_FILE;
                        end else if (r_nsz != ent_in.bytes) begin
                            n_rem   = '0;
                            n_quo   = cba_pkg::t_quo'(r_nsz) + cba_pkg::t_quo'(ubb) - 1'b1;
                            n_dcnt  = '0;
                            n_state = S_DIV;
                        end
                    end
                    default: begin
                        if (!r_valid[r_f]) begin
                            n_status = cba_pkg::ST_NO_FILE;
                        end
                    end
                endcase
            end
            S_MARK: begin
                if (r_cnt != '0) begin
                    if (32'(r_addr) < cba_pkg::BLOCKS) begin
                        map_we    = 1'b1;
                        map_wdata = r_mval;
                    end
                    n_addr = r_addr + 1'b1;
                    n_cnt  = r_cnt - 1'b1;
                end else begin
                    n_state = r_ret;
                end
            end
            S_DIV: begin
                n_rem = ge ? cba_pkg::t_rem'(rem_sh - {1'b0, ubb}) : rem_sh[cba_pkg::BB_W-1:0];
                n_quo = {r_quo[cba_pkg::QW-2:0], ge};
                if (r_dcnt == cba_pkg::t_dcnt'(cba_pkg::QW - 1)) begin
                    n_state = S_RSZ;
                end else begin
                    n_dcnt = r_dcnt + 1'b1;
                end
            end
            S_RSZ: begin
                if (r_nsz > r_ent.bytes) begin
                    n_need = need;
                    if (need == '0) begin
                        n_ent.bytes = r_nsz;
                        n_state     = S_WENT;
                    end else begin
                        n_second = 1'b0;
                        n_state  = S_TX;
                    end
                end else begin
                    n_ent.held  = tmin;
                    n_ent.bytes = r_nsz;
                    if (tmin == '0) begin
                        n_ent.placed = 1'b0;
                        n_ent.start  = '0;
                    end
                    if (r_ent.placed) begin
                        n_addr  = cba_pkg::t_wide'(r_ent.start) + cba_pkg::t_wide'(tmin);
                        n_cnt   = cba_pkg::t_wide'(r_ent.held - tmin);
                        n_mval  = 1'b0;
                        n_ret   = S_WENT;
                        n_state = S_MARK;
                    end else begin
                        n_state = S_WENT;
                    end
                end
            end
            S_TX: begin
                n_run  = '0;
                n_pend = 1'b0;
                n_cnt  = '0;
                if (r_ent.placed) begin
                    n_pos   = cba_pkg::t_wide'(r_ent.start) + cba_pkg::t_wide'(r_ent.held);
                    n_addr  = cba_pkg::t_wide'(r_ent.start) + cba_pkg::t_wide'(r_ent.held);
                    n_state = S_RUN;
                end else begin
                    n_create = 1'b0;
                    n_addr   = '0;
                    n_state  = S_FF;
                end
            end
            S_FF: begin
                if (r_pend && !r_map_q) begin
                    if (r_create) begin
                        map_we       = 1'b1;
                        map_waddr    = r_paddr[cba_pkg::BLK_AW-1:0];
                        map_wdata    = 1'b1;
                        n_ent.start  = r_paddr[cba_pkg::BLK_AW-1:0];
                        n_ent.placed = 1'b1;
                        n_ent.bytes  = '0;
                        n_ent.held   = cba_pkg::t_cnt'(1);
                        n_entv       = 1'b1;
                        n_state      = S_WENT;
                    end else begin
                        n_pos   = r_paddr;
                        n_addr  = r_paddr;
                        n_run   = '0;
                        n_pend  = 1'b0;
                        n_cnt   = '0;
                        n_state = S_RUN;
                    end
                end else if (r_addr < effx) begin
                    n_pend  = 1'b1;
                    n_paddr = r_addr;
                    n_addr  = r_addr + 1'b1;
                end else if (r_create) begin
                    n_status = cba_pkg::ST_NO_SPACE;
                    n_ret    = S_OUT;
                    n_state  = S_CNT0;
                end else begin
                    n_state = S_TXFAIL;
                end
            end
            S_RUN: begin
                if (!(r_pend && r_map_q) && can) begin
                    n_pend = 1'b1;
                    n_addr = r_addr + 1'b1;
                    n_cnt  = r_cnt + 1'b1;
                    n_run  = run1;
                end else if (cba_pkg::t_quo'(fin) == r_need) begin
                    n_addr  = r_pos;
                    n_cnt   = r_need[cba_pkg::BLK_XW-1:0];
                    n_mval  = 1'b1;
                    n_ret   = S_TXOK;
                    n_state = S_MARK;
                end else begin
                    n_state = S_TXFAIL;
                end
            end
            S_TXOK: begin
                if (!r_ent.placed) begin
                    n_ent.start  = r_pos[cba_pkg::BLK_AW-1:0];
                    n_ent.placed = 1'b1;
                end
                n_ent.held  = r_ent.held + r_need[cba_pkg::BLK_CW-1:0];
                n_ent.bytes = r_nsz;
                n_status    = r_second ? cba_pkg::ST_OK_COMPACT : cba_pkg::ST_OK;
                n_state     = S_WENT;
            end
            S_TXFAIL: begin
                if (r_second) begin
                    n_status = cba_pkg::ST_NO_SPACE;
                    n_state  = S_WENT;
                end else begin
                    n_ret   = S_CHK;
                    n_state = S_CNT0;
                end
            end
            S_CHK: begin
                if (cba_pkg::t_quo'(r_free) < r_need) begin
                    n_status = cba_pkg::ST_NO_SPACE;
                    n_state  = S_OUT;
                end else begin
                    n_second = 1'b1;
                    n_done   = '0;
                    n_addr   = '0;
                    n_ret    = S_CSTART;
                    n_state  = S_CLR;
                end
            end
            S_CSTART: begin
                n_next  = '0;
                n_state = S_CFI;
            end
            S_CFI: begin
                n_fidx   = '0;
                n_fpend  = 1'b0;
                n_bfound = 1'b0;
                n_state  = S_CFIND;
            end
            S_CFIND: begin
                if (cand) begin
                    n_best   = r_ent_q;
                    n_bidx   = r_fpaddr;
                    n_bfound = 1'b1;
                end
                if (32'(r_fidx) < cba_pkg::FILES) begin
                    n_fpend  = 1'b1;
                    n_fpaddr = r_fidx[cba_pkg::FILE_AW-1:0];
                    n_fidx   = r_fidx + 1'b1;
                end else begin
                    n_fpend = 1'b0;
                    n_state = bf ? S_CPLACE : S_CGROW;
                end
            end
            S_CPLACE: begin
                ent_we          = 1'b1;
                ent_waddr       = r_bidx;
                ent_wdata       = r_best;
                ent_wdata.start = r_next[cba_pkg::BLK_AW-1:0];
                n_done[r_bidx]  = 1'b1;
                n_addr          = r_next;
                n_cnt           = cba_pkg::t_wide'(r_best.held);
                n_mval          = 1'b1;
                n_next          = r_next + cba_pkg::t_wide'(r_best.held);
                n_ret           = S_CFI;
                n_state         = S_MARK;
            end
            S_CGROW: begin
                if (r_ent.placed) begin
                    n_ent.start = r_next[cba_pkg::BLK_AW-1:0];
                    n_addr      = r_next;
                    n_cnt       = cba_pkg::t_wide'(r_ent.held);
                    n_mval      = 1'b1;
                    n_ret       = S_TX;
                    n_state     = S_MARK;
                end else begin
                    n_state = S_TX;
                end
            end
            S_WENT: begin
                ent_we        = 1'b1;
                n_valid[r_f]  = r_entv;
                n_ret         = S_OUT;
                n_state       = S_CNT0;
            end
            S_CNT0: begin
                n_addr  = '0;
                n_pend  = 1'b0;
                n_free  = '0;
                n_state = S_CNT;
            end
            S_CNT: begin
                n_free = r_free + cba_pkg::t_cnt'(r_pend && !r_map_q);
                if (r_addr < effx) begin
                    n_pend = 1'b1;
                    n_addr = r_addr + 1'b1;
                end else begin
                    n_pend  = 1'b0;
                    n_state = r_ret;
                end
            end
            S_OUT: begin
                if (!n_ovalid) begin
                    n_ovalid  = 1'b1;
                    n_ostatus = r_status;
                    n_oplaced = r_entv && r_ent.placed;
                    n_ostart  = (r_entv && r_ent.placed) ?
                                cba_pkg::START_W'(r_ent.start) : '0;
                    n_ofree   = cba_pkg::FREE_W'(r_free);
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_ret    <= S_IDLE;
            r_addr   <= '0;
            r_valid  <= '0;
            r_done   <= '0;
            r_ovalid <= 1'b0;
            r_pend   <= 1'b0;
            r_fpend  <= 1'b0;
            r_bb     <= cba_pkg::BB_W'(64);
            r_biu    <= cba_pkg::BIU_W'(1024);
        end else begin
            r_state  <= n_state;
            r_ret    <= n_ret;
            r_addr   <= n_addr;
            r_valid  <= n_valid;
            r_done   <= n_done;
            r_ovalid <= n_ovalid;
            r_pend   <= n_pend;
            r_fpend  <= n_fpend;
            r_bb     <= n_bb;
            r_biu    <= n_biu;
        end
        r_kind    <= n_kind;     r_f      <= n_f;       r_nsz    <= n_nsz;
        r_ent     <= n_ent;      r_entv   <= n_entv;    r_status <= n_status;
        r_cnt     <= n_cnt;      r_paddr  <= n_paddr;   r_run    <= n_run;
        r_pos     <= n_pos;      r_need   <= n_need;    r_second <= n_second;
        r_free    <= n_free;     r_rem    <= n_rem;     r_quo    <= n_quo;
        r_dcnt    <= n_dcnt;     r_mval   <= n_mval;    r_create <= n_create;
        r_fidx    <= n_fidx;     r_fpaddr <= n_fpaddr;  r_bfound <= n_bfound;
        r_bidx    <= n_bidx;     r_best   <= n_best;    r_next   <= n_next;
        r_ostatus <= n_ostatus;  r_ostart <= n_ostart;  r_oplaced <= n_oplaced;
        r_ofree   <= n_ofree;
    end

endmodule

// File: src/cba_checker.sv
// Port-level checks of the allocator, bound to the top level.
module cba_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_req_valid,
    input  logic                          i_req_ready,
    input  logic                          i_rsp_valid,
    input  logic                          i_rsp_ready,
    input  logic [cba_pkg::STAT_W-1:0]    i_rsp_status,
    input  logic [cba_pkg::START_W-1:0]   i_rsp_start,
    input  logic                          i_rsp_placed,
    input  logic [cba_pkg::FREE_W-1:0]    i_rsp_free
);

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_rsp_status) &&
        $stable(i_rsp_start) && $stable(i_rsp_placed) && $stable(i_rsp_free))
        else $error("response changed while stalled");

    a_unplaced_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_placed |-> i_rsp_start == '0)
        else $error("unplaced file reports nonzero start");

    a_missing_unplaced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp_status == cba_pkg::ST_NO_FILE |-> !i_rsp_placed)
        else $error("missing file reported as placed");

    a_free_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> 32'(i_rsp_free) <= cba_pkg::BLOCKS)
        else $error("free count above block count");

    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready)
        else $error("second transaction taken while busy");

endmodule

bind contiguous_block_allocator_unit cba_checker u_cba_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_req_valid  (i_req.valid),
    .i_req_ready  (i_req.ready),
    .i_rsp_valid  (o_rsp.valid),
    .i_rsp_ready  (o_rsp.ready),
    .i_rsp_status (o_rsp.status),
    .i_rsp_start  (o_rsp.start_block),
    .i_rsp_placed (o_rsp.placed),
    .i_rsp_free   (o_rsp.free_count)
);
